[src/i2c_master_byte_engine_top_assert.svh]
// Assertion macros for the I2C master byte engine top level.
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/i2cm_pkg.sv]
// Package for the I2C master byte engine: types, codes and reset values.
`default_nettype none
package i2cm_pkg;

   // Command codes on the request word
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // Register indexes
   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_START_TICKS = 1'b1;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd5;
   localparam logic [15:0] START_TICKS_RESET = 16'd10;
   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ST_A     = 4'd1,
      PH_ST_B     = 4'd2,
      PH_SP_A     = 4'd3,
      PH_SP_B     = 4'd4,
      PH_WR_HIGH  = 4'd5,
      PH_WR_LOW   = 4'd6,
      PH_WR_REL   = 4'd7,
      PH_WR_ACK   = 4'd8,
      PH_WR_END   = 4'd9,
      PH_RD_LOW   = 4'd10,
      PH_RD_HIGH  = 4'd11,
      PH_RD_NACK  = 4'd12,
      PH_RD_NHIGH = 4'd13
   } phase_type;

   // Engine state carried from tick to tick
   typedef struct packed {
      phase_type   phase;
      logic [3:0]  bit_count;
      logic [15:0] tick_count;
      logic [7:0]  shift_reg;
      logic        scl_level;
      logic        sda_level;
      logic [7:0]  read_reg;
   } engine_state_type;

   // Accepted request word held in the input stage
   typedef struct packed {
      logic       valid;
      logic [2:0] command;
      logic [7:0] tx_byte;
      logic       sda_in;
   } in_word_type;

   // Per-tick flags from the step logic
   typedef struct packed {
      logic done;
      logic waiting;
   } step_flags_type;

   localparam engine_state_type ENGINE_RESET = '{
      phase:      PH_IDLE,
      bit_count:  4'd0,
      tick_count: 16'd0,
      shift_reg:  8'd0,
      scl_level:  1'b1,
      sda_level:  1'b1,
      read_reg:   8'd0
   };

endpackage
`default_nettype wire

[src/i2cm_in_stage.sv]
// Input register stage: takes one request word and holds it until the step advances.
`default_nettype none
module i2cm_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_command,
   input  wire logic [7:0]            req_tx_byte,
   input  wire logic                  req_sda_in,
   input  wire logic                  advance,
   output i2cm_pkg::in_word_type      word
);

   logic       valid_ff;
   logic       valid_in;
   logic [2:0] command_ff;
   logic [7:0] tx_byte_ff;
   logic       sda_in_ff;
   logic       take;

   // Stall only while a held word cannot move on this cycle
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         command_ff <= req_command;
         tx_byte_ff <= req_tx_byte;
         sda_in_ff  <= req_sda_in;
      end
   end

   assign word.valid   = valid_ff;
   assign word.command = command_ff;
   assign word.tx_byte = tx_byte_ff;
   assign word.sda_in  = sda_in_ff;

endmodule
`default_nettype wire

[src/i2cm_step.sv]
// One bus tick of the I2C master: next engine state and flags from the current state.
`default_nettype none
module i2cm_step (
   input  wire i2cm_pkg::engine_state_type cur,
   input  wire i2cm_pkg::in_word_type      word,
   input  wire logic [15:0]                phase_ticks,
   input  wire logic [15:0]                start_ticks,
   output i2cm_pkg::engine_state_type      nxt,
   output i2cm_pkg::step_flags_type        flags
);

   logic [15:0] tick_inc;
   logic [15:0] limit;
   logic        hold_over;
   logic [3:0]  bit_inc;
   logic        start_hold;

   // Hold counter: start phases use start_ticks, the rest phase_ticks
   assign start_hold = (cur.phase == i2cm_pkg::PH_ST_A) || (cur.phase == i2cm_pkg::PH_ST_B);
   assign limit      = start_hold ? start_ticks : phase_ticks;
   assign tick_inc   = cur.tick_count + 16'd1;
   assign hold_over  = (tick_inc >= limit) || (tick_inc == 16'd0);
   assign bit_inc    = cur.bit_count + 4'd1;

   always_comb begin
      nxt           = cur;
      flags.done    = 1'b0;
      flags.waiting = 1'b0;
      case (cur.phase)
         i2cm_pkg::PH_IDLE: begin
            nxt.tick_count = 16'd0;
            case (word.command)
               i2cm_pkg::CMD_START: begin
                  nxt.scl_level = 1'b1;
                  nxt.sda_level = 1'b1;
                  nxt.phase     = i2cm_pkg::PH_ST_A;
               end
               i2cm_pkg::CMD_STOP: begin
                  nxt.scl_level = 1'b0;
                  nxt.sda_level = 1'b0;
                  nxt.phase     = i2cm_pkg::PH_SP_A;
               end
               i2cm_pkg::CMD_WRITE: begin
                  nxt.shift_reg = word.tx_byte;
                  nxt.bit_count = 4'd0;
                  nxt.sda_level = word.tx_byte[7];
                  nxt.scl_level = 1'b1;
                  nxt.phase     = i2cm_pkg::PH_WR_HIGH;
               end
               i2cm_pkg::CMD_READ: begin
                  nxt.shift_reg = 8'd0;
                  nxt.bit_count = 4'd0;
                  nxt.scl_level = 1'b0;
                  nxt.sda_level = 1'b1;
                  nxt.phase     = i2cm_pkg::PH_RD_LOW;
               end
               default: ;  // no command, unused codes too
            endcase
         end
         i2cm_pkg::PH_ST_A,
         i2cm_pkg::PH_ST_B,
         i2cm_pkg::PH_SP_A,
         i2cm_pkg::PH_SP_B,
         i2cm_pkg::PH_WR_HIGH,
         i2cm_pkg::PH_WR_END,
         i2cm_pkg::PH_RD_LOW,
         i2cm_pkg::PH_RD_HIGH,
         i2cm_pkg::PH_RD_NHIGH: begin
            // Timed hold steps
            nxt.tick_count = hold_over ? 16'd0 : tick_inc;
            if (hold_over) begin
               case (cur.phase)
                  i2cm_pkg::PH_ST_A: begin
                     nxt.sda_level = 1'b0;
                     nxt.phase     = i2cm_pkg::PH_ST_B;
                  end
                  i2cm_pkg::PH_ST_B: begin
                     nxt.scl_level = 1'b0;
                     nxt.phase     = i2cm_pkg::PH_IDLE;
                     flags.done    = 1'b1;
                  end
                  i2cm_pkg::PH_SP_A: begin
                     nxt.scl_level = 1'b1;
                     nxt.phase     = i2cm_pkg::PH_SP_B;
                  end
                  i2cm_pkg::PH_SP_B: begin
                     nxt.sda_level = 1'b1;
                     nxt.phase     = i2cm_pkg::PH_IDLE;
                     flags.done    = 1'b1;
                  end
                  i2cm_pkg::PH_WR_HIGH: begin
                     nxt.scl_level = 1'b0;
                     nxt.shift_reg = {cur.shift_reg[6:0], 1'b0};
                     nxt.bit_count = bit_inc;
                     nxt.phase     = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                                     i2cm_pkg::PH_WR_REL : i2cm_pkg::PH_WR_LOW;
                  end
                  i2cm_pkg::PH_WR_END: begin
                     nxt.phase  = i2cm_pkg::PH_IDLE;
                     flags.done = 1'b1;
                  end
                  i2cm_pkg::PH_RD_LOW: begin
                     nxt.scl_level = 1'b1;
                     nxt.phase     = i2cm_pkg::PH_RD_HIGH;
                  end
                  i2cm_pkg::PH_RD_HIGH: begin
                     // Sample SDA at the end of the high phase
                     nxt.shift_reg = {cur.shift_reg[6:0], word.sda_in};
                     nxt.scl_level = 1'b0;
                     nxt.bit_count = bit_inc;
                     if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        nxt.read_reg = {cur.shift_reg[6:0], word.sda_in};
                        nxt.phase    = i2cm_pkg::PH_RD_NACK;
                     end else begin
                        nxt.phase    = i2cm_pkg::PH_RD_LOW;
                     end
                  end
                  default: begin  // read NACK high phase
                     nxt.scl_level = 1'b0;
                     nxt.phase     = i2cm_pkg::PH_IDLE;
                     flags.done    = 1'b1;
                  end
               endcase
            end
         end
         i2cm_pkg::PH_WR_LOW: begin
            nxt.sda_level  = cur.shift_reg[7];
            nxt.scl_level  = 1'b1;
            nxt.tick_count = 16'd0;
            nxt.phase      = i2cm_pkg::PH_WR_HIGH;
         end
         i2cm_pkg::PH_WR_REL: begin
            nxt.sda_level = 1'b1;
            nxt.scl_level = 1'b1;
            nxt.phase     = i2cm_pkg::PH_WR_ACK;
         end
         i2cm_pkg::PH_WR_ACK: begin
            // Wait with SCL high for the slave to pull SDA low
            if (!word.sda_in) begin
               nxt.scl_level  = 1'b0;
               nxt.tick_count = 16'd0;
               nxt.phase      = i2cm_pkg::PH_WR_END;
            end else begin
               flags.waiting = 1'b1;
            end
         end
         i2cm_pkg::PH_RD_NACK: begin
            nxt.sda_level  = 1'b1;
            nxt.scl_level  = 1'b1;
            nxt.tick_count = 16'd0;
            nxt.phase      = i2cm_pkg::PH_RD_NHIGH;
         end
         default: begin
            nxt.phase = i2cm_pkg::PH_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[src/i2c_master_byte_engine_top.sv]
// A request word accepted into the input register goes through one engine step
// into the result register, while the result side is free or draining.
// Throughput: one word per cycle unless the result side stalls; state
// advances only as words move on.
// Reset (synchronous, active high) returns the engine to idle with both lines
// released, clears the read byte and loads the default hold counts.
`default_nettype none
module i2c_master_byte_engine_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        req_sda_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_out,
   output logic             rsp_sda_out,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic             rsp_ack_wait,
   output logic [7:0]       rsp_rx_byte,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   `include "i2c_master_byte_engine_top_assert.svh"

   logic [15:0]                phase_ticks_ff;
   logic [15:0]                start_ticks_ff;
   i2cm_pkg::engine_state_type state_ff;
   i2cm_pkg::engine_state_type state_in;
   i2cm_pkg::in_word_type      word;
   i2cm_pkg::step_flags_type   flags;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       advance;

   // Step moves when a word is held and the result register is free or draining
   assign advance = word.valid && (!rsp_valid_ff || !rsp_stall);

   i2cm_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_tx_byte (req_tx_byte),
      .req_sda_in  (req_sda_in),
      .advance     (advance),
      .word        (word)
   );

   i2cm_step u_step (
      .cur         (state_ff),
      .word        (word),
      .phase_ticks (phase_ticks_ff),
      .start_ticks (start_ticks_ff),
      .nxt         (state_in),
      .flags       (flags)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cm_pkg::PHASE_TICKS_RESET;
         start_ticks_ff <= i2cm_pkg::START_TICKS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            i2cm_pkg::CSR_PHASE_TICKS: phase_ticks_ff <= csr_wdata;
            i2cm_pkg::CSR_START_TICKS: start_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Engine state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2cm_pkg::ENGINE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result word, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_scl_out  <= state_in.scl_level;
         rsp_sda_out  <= state_in.sda_level;
         rsp_busy_res <= (state_in.phase != i2cm_pkg::PH_IDLE);
         rsp_done_res <= flags.done;
         rsp_ack_wait <= flags.waiting;
         rsp_rx_byte  <= state_in.read_reg;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Checks
   `I2CM_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res, "done word reports busy")
   `I2CM_ASSERT_NOW(a_ack_lines, clock, reset, rsp_valid && rsp_ack_wait, rsp_busy_res && rsp_scl_out && rsp_sda_out, "ack wait without both lines released")
   `I2CM_ASSERT_NOW(a_stall_held, clock, reset, req_stall, word.valid && rsp_valid_ff && rsp_stall, "input stalled without a blocked word")
   `I2CM_ASSERT_NEXT(a_idle_on_done, clock, reset, advance && flags.done, state_ff.phase == i2cm_pkg::PH_IDLE, "engine not idle after done")

endmodule
`default_nettype wire

[sim/i2c_master_byte_engine_checker.sv]
// Checker for the I2C master byte engine: predicts each result word and compares it.
`default_nettype none
module i2c_master_byte_engine_checker
   import i2cm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        req_sda_in,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_scl_out,
   input  wire logic        rsp_sda_out,
   input  wire logic        rsp_busy_res,
   input  wire logic        rsp_done_res,
   input  wire logic        rsp_ack_wait,
   input  wire logic [7:0]  rsp_rx_byte,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        run_over,
   output int               failures
);

   // One result word as the engine reports it
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic       waiting;
      logic [7:0] rx;
   } pin_word_type;

   pin_word_type     pending_pins[$];
   pin_word_type     oldest_pins;
   engine_state_type bus;
   logic [15:0]      hold_phase;
   logic [15:0]      hold_start;
   logic             tallied;

   // Count one tick of a hold; a limit of zero behaves as one
   function automatic logic hold_elapsed(input logic [15:0] limit);
      bus.tick_count = bus.tick_count + 16'd1;
      if (bus.tick_count >= limit || bus.tick_count == 16'd0) begin
         bus.tick_count = 16'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // One bus tick of the engine
   function automatic pin_word_type advance_bus_tick(input logic [2:0] cmd,
                                                     input logic [7:0] tx,
                                                     input logic       sdi);
      pin_word_type w;
      logic         fin;
      logic         hanging;
      fin     = 1'b0;
      hanging = 1'b0;
      case (bus.phase)
         PH_IDLE: begin
            bus.tick_count = 16'd0;
            // codes above read act as no command
            case (cmd)
               CMD_START: begin
                  bus.scl_level = 1'b1;
                  bus.sda_level = 1'b1;
                  bus.phase     = PH_ST_A;
               end
               CMD_STOP: begin
                  bus.scl_level = 1'b0;
                  bus.sda_level = 1'b0;
                  bus.phase     = PH_SP_A;
               end
               CMD_WRITE: begin
                  bus.shift_reg = tx;
                  bus.bit_count = 4'd0;
                  bus.sda_level = tx[7];
                  bus.scl_level = 1'b1;
                  bus.phase     = PH_WR_HIGH;
               end
               CMD_READ: begin
                  bus.shift_reg = 8'd0;
                  bus.bit_count = 4'd0;
                  bus.scl_level = 1'b0;
                  bus.sda_level = 1'b1;
                  bus.phase     = PH_RD_LOW;
               end
               default: ;
            endcase
         end
         PH_ST_A: begin
            if (hold_elapsed(hold_start)) begin
               bus.sda_level = 1'b0;
               bus.phase     = PH_ST_B;
            end
         end
         PH_ST_B: begin
            if (hold_elapsed(hold_start)) begin
               bus.scl_level = 1'b0;
               bus.phase     = PH_IDLE;
               fin           = 1'b1;
            end
         end
         PH_SP_A: begin
            if (hold_elapsed(hold_phase)) begin
               bus.scl_level = 1'b1;
               bus.phase     = PH_SP_B;
            end
         end
         PH_SP_B: begin
            if (hold_elapsed(hold_phase)) begin
               bus.sda_level = 1'b1;
               bus.phase     = PH_IDLE;
               fin           = 1'b1;
            end
         end
         PH_WR_HIGH: begin
            if (hold_elapsed(hold_phase)) begin
               bus.scl_level = 1'b0;
               bus.shift_reg = {bus.shift_reg[6:0], 1'b0};
               bus.bit_count = bus.bit_count + 4'd1;
               bus.phase     = (bus.bit_count >= BITS_PER_BYTE) ? PH_WR_REL : PH_WR_LOW;
            end
         end
         PH_WR_LOW: begin
            bus.sda_level  = bus.shift_reg[7];
            bus.scl_level  = 1'b1;
            bus.tick_count = 16'd0;
            bus.phase      = PH_WR_HIGH;
         end
         PH_WR_REL: begin
            bus.sda_level = 1'b1;
            bus.scl_level = 1'b1;
            bus.phase     = PH_WR_ACK;
         end
         PH_WR_ACK: begin
            // no timeout: waits as long as the slave holds SDA high
            if (!sdi) begin
               bus.scl_level  = 1'b0;
               bus.tick_count = 16'd0;
               bus.phase      = PH_WR_END;
            end else begin
               hanging = 1'b1;
            end
         end
         PH_WR_END: begin
            if (hold_elapsed(hold_phase)) begin
               bus.phase = PH_IDLE;
               fin       = 1'b1;
            end
         end
         PH_RD_LOW: begin
            if (hold_elapsed(hold_phase)) begin
               bus.scl_level = 1'b1;
               bus.phase     = PH_RD_HIGH;
            end
         end
         PH_RD_HIGH: begin
            if (hold_elapsed(hold_phase)) begin
               bus.shift_reg = {bus.shift_reg[6:0], sdi};
               bus.scl_level = 1'b0;
               bus.bit_count = bus.bit_count + 4'd1;
               if (bus.bit_count >= BITS_PER_BYTE) begin
                  bus.read_reg = bus.shift_reg;
                  bus.phase    = PH_RD_NACK;
               end else begin
                  bus.phase = PH_RD_LOW;
               end
            end
         end
         PH_RD_NACK: begin
            bus.sda_level  = 1'b1;
            bus.scl_level  = 1'b1;
            bus.tick_count = 16'd0;
            bus.phase      = PH_RD_NHIGH;
         end
         PH_RD_NHIGH: begin
            if (hold_elapsed(hold_phase)) begin
               bus.scl_level = 1'b0;
               bus.phase     = PH_IDLE;
               fin           = 1'b1;
            end
         end
         default: bus.phase = PH_IDLE;
      endcase
      w.scl     = bus.scl_level;
      w.sda     = bus.sda_level;
      w.busy    = (bus.phase != PH_IDLE);
      w.done    = fin;
      w.waiting = hanging;
      w.rx      = bus.read_reg;
      return w;
   endfunction

   task automatic check_field(input string name, input int want, input int seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         failures++;
      end
   endtask

   // Sample mid-cycle, where every handshake signal has settled
   always @(negedge clock) begin
      if (reset) begin
         bus        = ENGINE_RESET;
         hold_phase = PHASE_TICKS_RESET;
         hold_start = START_TICKS_RESET;
         pending_pins.delete();
         failures   = 0;
         tallied    = 1'b0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_PHASE_TICKS) hold_phase = csr_wdata;
            else hold_start = csr_wdata;
         end
         if (req_valid && !req_stall)
            pending_pins.push_back(advance_bus_tick(req_command, req_tx_byte, req_sda_in));
         if (rsp_valid && !rsp_stall) begin
            if (pending_pins.size() == 0) begin
               $error("result word with no prediction outstanding");
               failures++;
            end else begin
               oldest_pins = pending_pins.pop_front();
               check_field("scl_out",  oldest_pins.scl,     rsp_scl_out);
               check_field("sda_out",  oldest_pins.sda,     rsp_sda_out);
               check_field("busy_res", oldest_pins.busy,    rsp_busy_res);
               check_field("done_res", oldest_pins.done,    rsp_done_res);
               check_field("ack_wait", oldest_pins.waiting, rsp_ack_wait);
               check_field("rx_byte",  oldest_pins.rx,      rsp_rx_byte);
            end
         end
         // anything still predicted at the end never arrived
         if (run_over && !tallied) begin
            if (pending_pins.size() != 0) begin
               $error("%0d predicted result words never arrived", pending_pins.size());
               failures += pending_pins.size();
            end
            tallied = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[sim/testbench.sv]
// Top of the I2C master byte engine testbench: stimulus, idling and the verdict.
`default_nettype none
module testbench;
   import i2cm_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command  = CMD_NONE;
   logic [7:0]  req_tx_byte  = 8'd0;
   logic        req_sda_in   = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic        rsp_scl_out;
   logic        rsp_sda_out;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_ack_wait;
   logic [7:0]  rsp_rx_byte;
   logic        csr_write_en = 1'b0;
   logic        csr_index    = CSR_PHASE_TICKS;
   logic [15:0] csr_wdata    = 16'd0;
   logic        run_over     = 1'b0;
   int          fail_total;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int words_sent    = 0;
   int words_back    = 0;
   int dones_back    = 0;
   int cycle_count   = 0;
   logic last_busy   = 1'b0;

   i2c_master_byte_engine_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_tx_byte(req_tx_byte), .req_sda_in(req_sda_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_scl_out(rsp_scl_out), .rsp_sda_out(rsp_sda_out),
      .rsp_busy_res(rsp_busy_res), .rsp_done_res(rsp_done_res),
      .rsp_ack_wait(rsp_ack_wait), .rsp_rx_byte(rsp_rx_byte),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   i2c_master_byte_engine_checker watch (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_tx_byte(req_tx_byte), .req_sda_in(req_sda_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_scl_out(rsp_scl_out), .rsp_sda_out(rsp_sda_out),
      .rsp_busy_res(rsp_busy_res), .rsp_done_res(rsp_done_res),
      .rsp_ack_wait(rsp_ack_wait), .rsp_rx_byte(rsp_rx_byte),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .run_over(run_over), .failures(fail_total)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver stalls at random
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // Guard against a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Track returned words so stimulus knows when the engine is quiet
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_back++;
         last_busy = rsp_busy_res;
         if (rsp_done_res) dones_back++;
      end
   end

   // Offer one word, with an optional random gap first; returns on the accepting edge
   task automatic send_item(input logic [2:0] cmd, input logic [7:0] tx, input logic sdi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_tx_byte <= tx;
      req_sda_in  <= sdi;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      words_sent++;
   endtask

   // Put a command on the bus, then keep ticking until a command completes
   task automatic issue(input logic [2:0] cmd, input logic [7:0] tx,
                        input int noise_pct, input int sda_one_pct);
      int   mark;
      logic [2:0] filler;
      mark = dones_back;
      send_item(cmd, tx, $urandom_range(99) < sda_one_pct);
      while (dones_back == mark) begin
         filler = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : CMD_NONE;
         send_item(filler, 8'($urandom), $urandom_range(99) < sda_one_pct);
      end
   endtask

   // Tick the engine until it reports idle and every word is back
   task automatic drain_engine();
      logic still_busy;
      do begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (words_back != words_sent) @(posedge clock);
         still_busy = last_busy;
         while (last_busy) send_item(CMD_NONE, 8'($urandom), 1'($urandom_range(1)));
      end while (still_busy);
   endtask

   task automatic set_holds(input logic [15:0] phase_val, input logic [15:0] start_val);
      drain_engine();
      repeat (3) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_PHASE_TICKS;
      csr_wdata    <= phase_val;
      @(posedge clock);
      csr_index    <= CSR_START_TICKS;
      csr_wdata    <= start_val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly short holds, now and then zero or a longer one
   function automatic logic [15:0] pick_hold();
      int r;
      r = $urandom_range(19);
      if (r == 0) return 16'd0;
      if (r < 16) return 16'($urandom_range(1, 4));
      return 16'($urandom_range(5, 40));
   endfunction

   initial begin
      int phase_mark;
      int choice;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 12;
      recv_idle_pct = 61;

      // Directed: reset holds, idle ticks, unused codes and every command
      send_item(CMD_NONE, 8'h00, 1'b1);
      send_item(3'd5, 8'hFF, 1'b0);
      send_item(3'd6, 8'h55, 1'b1);
      send_item(3'd7, 8'hAA, 1'b0);
      issue(CMD_START, 8'h00, 0, 50);
      issue(CMD_WRITE, 8'hA5, 0, 50);
      // slave slow to acknowledge
      issue(CMD_WRITE, 8'h00, 0, 95);
      issue(CMD_WRITE, 8'hFF, 0, 50);
      issue(CMD_READ, 8'h00, 0, 100);
      issue(CMD_READ, 8'hFF, 0, 0);
      // commands arriving while a start is under way
      issue(CMD_START, 8'h3C, 100, 50);
      issue(CMD_STOP, 8'h00, 0, 50);

      // Zero holds behave as one tick
      set_holds(16'd0, 16'd0);
      issue(CMD_START, 8'h00, 0, 50);
      issue(CMD_WRITE, 8'h80, 0, 50);
      issue(CMD_READ, 8'h00, 0, 50);
      issue(CMD_STOP, 8'h00, 0, 50);

      set_holds(16'd1, 16'd1);
      issue(CMD_START, 8'h00, 0, 50);
      issue(CMD_WRITE, 8'h01, 0, 50);
      issue(CMD_STOP, 8'h00, 0, 50);

      // Random traffic over three idling regimes
      for (int p = 0; p < 3; p++) begin
         if (p == 1) begin
            send_idle_pct = 61;
            recv_idle_pct = 12;
         end else if (p == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_holds(pick_hold(), pick_hold());
         phase_mark = words_sent;
         while (words_sent - phase_mark < 350) begin
            if ($urandom_range(5) == 0) set_holds(pick_hold(), pick_hold());
            choice = $urandom_range(9);
            if (choice < 8) begin
               // start, one to three bytes, stop
               issue(CMD_START, 8'($urandom), 8, 50);
               repeat ($urandom_range(1, 3)) begin
                  if ($urandom_range(1)) issue(CMD_WRITE, 8'($urandom), 8, 50);
                  else issue(CMD_READ, 8'($urandom), 8, 50);
               end
               issue(CMD_STOP, 8'($urandom), 8, 50);
            end else if (choice == 8) begin
               // burst of raw words with any code
               repeat ($urandom_range(1, 12))
                  send_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
            end else begin
               // bytes with no start or stop around them
               issue(CMD_READ, 8'($urandom), 30, 50);
               issue(CMD_WRITE, 8'($urandom), 30, 50);
            end
         end
      end

      // Long holds, with no idling on either side
      set_holds(16'd40, 16'd40);
      issue(CMD_START, 8'h00, 0, 50);
      issue(CMD_STOP, 8'h00, 0, 50);

      req_valid <= 1'b0;
      @(posedge clock);
      while (words_back != words_sent) @(posedge clock);
      repeat (10) @(posedge clock);
      run_over <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_total == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire
